// ===== hw/rtl/hcf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and character decode functions for the hex command framer.
package hcf_pkg;

    localparam logic [7:0] SKIP_MAX  = 8'd32;   // space and control characters
    localparam logic [7:0] CHAR_MAX  = 8'h7A;   // 'z'
    localparam logic [7:0] LIST_CMD  = 8'h6C;   // 'l'

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] cmd;
        logic       has_data;
        logic [7:0] data;
        logic [7:0] index;
        logic       last;
    } t_result;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_status;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        logic [7:0] d;
        h = '0;
        d = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            h.ok = 1'b1;
            h.val = d[3:0];
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            h.ok = 1'b1;
            h.val = d[3:0];
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            h.ok = 1'b1;
            h.val = d[3:0];
        end
        return h;
    endfunction

    // l d D m u t T e E
    function automatic logic is_known(input logic [7:0] c);
        logic k;
        unique case (c) inside
            8'h6C, 8'h64, 8'h44, 8'h6D, 8'h75, 8'h74, 8'h54, 8'h65, 8'h45: k = 1'b1;
            default: k = 1'b0;
        endcase
        return k;
    endfunction

endpackage

// ===== hw/rtl/hcf_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts characters, tracks command framing and builds result records.
module hcf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_rx_byte,
    input  hcf_pkg::t_q_status i_q_status,
    output logic              o_stall,
    output logic              o_push,
    output hcf_pkg::t_result  o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN_HI,
        S_LEN_LO,
        S_DATA_HI,
        S_DATA_LO
    } t_state;

    t_state      r_state, n_state;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_len, n_len;
    logic [3:0]  r_high, n_high;
    logic [7:0]  r_count, n_count;

    logic         accept;
    hcf_pkg::t_hex hx;
    logic [7:0]   len_full;
    logic         last_byte;

    assign o_stall   = i_q_status.full;
    assign accept    = i_valid && !i_q_status.full;
    assign hx        = hcf_pkg::hex_value(i_rx_byte);
    assign len_full  = {r_len[7:4], hx.val};
    assign last_byte = ({1'b0, r_count} + 9'd1) >= {1'b0, r_len};

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_len    = r_len;
        n_high   = r_high;
        n_count  = r_count;
        o_push   = 1'b0;
        o_result = '0;
        if (accept) begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_rx_byte > hcf_pkg::SKIP_MAX && i_rx_byte <= hcf_pkg::CHAR_MAX) begin
                        if (i_rx_byte == hcf_pkg::LIST_CMD) begin
                            o_push        = 1'b1;
                            o_result.cmd  = i_rx_byte;
                            o_result.last = 1'b1;
                        end else begin
                            n_cmd   = i_rx_byte;
                            n_state = S_LEN_HI;
                        end
                    end
                end
                S_LEN_HI: begin
                    if (hx.ok) begin
                        n_len   = {hx.val, 4'h0};
                        n_state = S_LEN_LO;
                    end
                end
                S_LEN_LO: begin
                    if (hx.ok) begin
                        if (len_full == 8'd0) begin
                            // empty payload: close the command now
                            o_push        = 1'b1;
                            o_result.cmd  = r_cmd;
                            o_result.last = 1'b1;
                            n_state       = S_IDLE;
                        end else begin
                            n_len   = len_full;
                            n_count = 8'd0;
                            n_state = S_DATA_HI;
                        end
                    end
                end
                S_DATA_HI: begin
                    if (hx.ok) begin
                        n_high  = hx.val;
                        n_state = S_DATA_LO;
                    end
                end
                S_DATA_LO: begin
                    if (hx.ok) begin
                        o_push            = 1'b1;
                        o_result.cmd      = r_cmd;
                        o_result.has_data = 1'b1;
                        o_result.data     = {r_high, hx.val};
                        o_result.index    = r_count;
                        o_result.last     = last_byte;
                        if (last_byte) begin
                            n_state = S_IDLE;
                        end else begin
                            n_count = r_count + 8'd1;
                            n_state = S_DATA_HI;
                        end
                    end
                end
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= '0;
            r_len   <= '0;
            r_high  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_high  <= n_high;
            r_count <= n_count;
        end
    end

endmodule

// ===== hw/rtl/hcf_queue.sv =====
`timescale 1ns / 1ps
// Short result queue between the framing front end and the output stage.
module hcf_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  hcf_pkg::t_result   i_result,
    input  logic               i_pop,
    output hcf_pkg::t_q_status o_status,
    output hcf_pkg::t_result   o_result
);

    hcf_pkg::t_result r_mem [hcf_pkg::QDEPTH];
    logic [hcf_pkg::QAW-1:0] r_wr_ptr;
    logic [hcf_pkg::QAW-1:0] r_rd_ptr;
    logic [hcf_pkg::QCW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_status.full      = (r_count == hcf_pkg::QCW'(hcf_pkg::QDEPTH));
    assign o_status.not_empty = (r_count != '0);
    assign do_push            = i_push && !o_status.full;
    assign do_pop             = i_pop && o_status.not_empty;
    assign o_result           = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/hcf_back.sv =====
`timescale 1ns / 1ps
// Output stage: pops results from the queue and presents them on the output request.
module hcf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hcf_pkg::t_q_status i_q_status,
    input  hcf_pkg::t_result   i_result,
    input  logic               i_stall,
    output logic               o_pop,
    output logic               o_valid,
    output hcf_pkg::t_result   o_result,
    output logic               o_known
);

    logic             r_valid;
    hcf_pkg::t_result r_result;
    logic             r_known;

    // refill when the register is empty or its request is taken this cycle
    assign o_pop    = i_q_status.not_empty && (!r_valid || !i_stall);
    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_known  = r_known;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_result;
            r_known  <= hcf_pkg::is_known(i_result.cmd);
        end
    end

endmodule

// ===== hw/rtl/hex_command_framer_unit.sv =====
`timescale 1ns / 1ps
// Top level of the hex command framer: front end, result queue and output stage.
//
//  channel   direction  handshake          payload
//  input     in         i_valid / o_stall  i_rx_byte
//  output    out        o_valid / i_stall  o_command_code, o_known_command, o_has_data,
//                                          o_data_byte, o_data_index, o_last_of_command
//
// One character is taken every cycle while o_stall is low; the front end updates its
// framing state when it accepts the character. A result is pushed at the edge that
// accepts its character and reaches the output register at the next edge at the earliest.
// o_stall rises only when the four-entry result queue is full.
// Reset is synchronous and active low; it returns the framer to idle and empties the queue.
module hex_command_framer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_command_code,
    output logic       o_known_command,
    output logic       o_has_data,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_data_index,
    output logic       o_last_of_command
);

    hcf_pkg::t_q_status q_status;
    hcf_pkg::t_result   push_result;
    hcf_pkg::t_result   head_result;
    hcf_pkg::t_result   out_result;
    logic               push;
    logic               pop;

    hcf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_rx_byte  (i_rx_byte),
        .i_q_status (q_status),
        .o_stall    (o_stall),
        .o_push     (push),
        .o_result   (push_result)
    );

    hcf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (push_result),
        .i_pop    (pop),
        .o_status (q_status),
        .o_result (head_result)
    );

    hcf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_result   (head_result),
        .i_stall    (i_stall),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_result   (out_result),
        .o_known    (o_known_command)
    );

    assign o_command_code    = out_result.cmd;
    assign o_has_data        = out_result.has_data;
    assign o_data_byte       = out_result.data;
    assign o_data_index      = out_result.index;
    assign o_last_of_command = out_result.last;

endmodule

// ===== hw/rtl/hcf_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the hex command framer and its bind to the top level.
module hcf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_command_code,
    input logic       o_known_command,
    input logic       o_has_data,
    input logic [7:0] o_data_byte,
    input logic [7:0] o_data_index,
    input logic       o_last_of_command
);

    // a request without data always closes its command
    a_nodata_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_data |-> o_last_of_command)
        else $error("request without data is not marked last");

    a_nodata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_data |-> o_data_byte == 8'd0 && o_data_index == 8'd0)
        else $error("request without data carries nonzero data or index");

    a_known_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_known_command |->
            o_command_code == 8'h6C || o_command_code == 8'h64 || o_command_code == 8'h44 ||
            o_command_code == 8'h6D || o_command_code == 8'h75 || o_command_code == 8'h74 ||
            o_command_code == 8'h54 || o_command_code == 8'h65 || o_command_code == 8'h45)
        else $error("known flag set on an unlisted command letter");

    // hold a stalled request
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_command_code) && $stable(o_data_byte)
            && $stable(o_data_index) && $stable(o_last_of_command))
        else $error("stalled output request changed");

endmodule

bind hex_command_framer_unit hcf_checker u_hcf_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_command_code    (o_command_code),
    .o_known_command   (o_known_command),
    .o_has_data        (o_has_data),
    .o_data_byte       (o_data_byte),
    .o_data_index      (o_data_index),
    .o_last_of_command (o_last_of_command)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the hex command framer: directed table, random command streams.
module tb_top;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_AT      = 50;
    localparam int LONG_AT      = 150;
    localparam int PAUSE_AT     = 500;

    typedef struct packed {
        logic [7:0] cmd;
        logic       known;
        logic       has_data;
        logic [7:0] data;
        logic [7:0] index;
        logic       last;
    } t_frame_result;

    typedef struct packed {
        logic [7:0]    ch;
        logic          typed;
        t_frame_result res;
    } t_stim_row;

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_PULSE} t_rx_mode;

    localparam t_frame_result NO_RES = '0;
    localparam logic [7:0] KNOWN_CMDS [9] = '{"l", "d", "D", "m", "u", "t", "T", "e", "E"};

    // typed rows: list command, zero length, extremes of the payload byte
    localparam int DIR_ROWS = 25;
    localparam t_stim_row DIR_TABLE [DIR_ROWS] = '{
        '{8'h00, 1'b0, NO_RES},
        '{8'h20, 1'b0, NO_RES},
        '{8'h7B, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{"l",   1'b1, '{"l", 1'b1, 1'b0, 8'h00, 8'h00, 1'b1}},
        '{"d",   1'b0, NO_RES},
        '{"0",   1'b0, NO_RES},
        '{"0",   1'b1, '{"d", 1'b1, 1'b0, 8'h00, 8'h00, 1'b1}},
        '{8'h21, 1'b0, NO_RES},
        '{"x",   1'b0, NO_RES},
        '{"0",   1'b0, NO_RES},
        '{"2",   1'b0, NO_RES},
        '{"F",   1'b0, NO_RES},
        '{"f",   1'b1, '{8'h21, 1'b0, 1'b1, 8'hFF, 8'h00, 1'b0}},
        '{8'h80, 1'b0, NO_RES},
        '{"0",   1'b0, NO_RES},
        '{"0",   1'b1, '{8'h21, 1'b0, 1'b1, 8'h00, 8'h01, 1'b1}},
        '{"z",   1'b0, NO_RES},
        '{"0",   1'b0, NO_RES},
        '{"1",   1'b0, NO_RES},
        '{"a",   1'b0, NO_RES},
        '{"B",   1'b0, NO_RES},
        '{"E",   1'b0, NO_RES},
        '{"0",   1'b0, NO_RES},
        '{"0",   1'b1, '{"E", 1'b1, 1'b0, 8'h00, 8'h00, 1'b1}}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_command_code;
    logic       o_known_command;
    logic       o_has_data;
    logic [7:0] o_data_byte;
    logic [7:0] o_data_index;
    logic       o_last_of_command;

    hex_command_framer_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .i_rx_byte         (i_rx_byte),
        .o_stall           (o_stall),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_command_code    (o_command_code),
        .o_known_command   (o_known_command),
        .o_has_data        (o_has_data),
        .o_data_byte       (o_data_byte),
        .o_data_index      (o_data_index),
        .o_last_of_command (o_last_of_command)
    );

    always #4 i_clk = ~i_clk;

    // framing state of the predictor
    logic [7:0] cur_cmd;
    logic [8:0] digit_cnt;
    logic [7:0] frame_len;
    logic [3:0] hi_digit;
    logic [7:0] emit_cnt;

    t_frame_result frame_q[$];
    int  err_cnt = 0;
    int  cyc = 0;
    int  sent_cnt = 0;
    int  burst_left = 0;
    logic hold_req = 1'b0;

    function automatic logic cmd_known(input logic [7:0] c);
        logic k;
        k = 1'b0;
        foreach (KNOWN_CMDS[i])
            if (KNOWN_CMDS[i] == c) k = 1'b1;
        return k;
    endfunction

    // bit 4 set when c is a hex digit, low nibble is its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
        if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
        if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
        return 5'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] base;
        base = $urandom_range(1) ? "A" : "a";
        return (nib < 4'd10) ? 8'("0" + nib) : 8'(base + nib - 8'd10);
    endfunction

    function automatic t_frame_result make_result(input logic [7:0] c, input logic with_data,
                                                  input logic [7:0] value,
                                                  input logic [7:0] idx, input logic last);
        t_frame_result r;
        r.cmd      = c;
        r.known    = cmd_known(c);
        r.has_data = with_data;
        r.data     = with_data ? value : 8'h00;
        r.index    = with_data ? idx : 8'h00;
        r.last     = last;
        return r;
    endfunction

    task automatic clear_frame();
        cur_cmd   = 8'h00;
        digit_cnt = 9'd0;
        frame_len = 8'h00;
        hi_digit  = 4'h0;
        emit_cnt  = 8'h00;
    endtask

    task automatic frame_byte(input logic [7:0] ch, output logic got, output t_frame_result r);
        logic [4:0] hv;
        logic       last;
        hv  = hex_digit(ch);
        got = 1'b0;
        r   = NO_RES;
        if (cur_cmd == 8'h00) begin
            if (ch > hcf_pkg::SKIP_MAX && ch <= hcf_pkg::CHAR_MAX) begin
                if (ch == hcf_pkg::LIST_CMD) begin
                    got = 1'b1;
                    r = make_result(ch, 1'b0, 8'h00, 8'h00, 1'b1);
                end else begin
                    clear_frame();
                    cur_cmd = ch;
                end
            end
        end else if (hv[4]) begin
            if (digit_cnt == 9'd0) begin
                frame_len = {hv[3:0], 4'h0};
                digit_cnt = 9'd1;
            end else if (digit_cnt == 9'd1) begin
                frame_len[3:0] = hv[3:0];
                digit_cnt = 9'd2;
                if (frame_len == 8'h00) begin
                    got = 1'b1;
                    r = make_result(cur_cmd, 1'b0, 8'h00, 8'h00, 1'b1);
                    clear_frame();
                end
            end else begin
                digit_cnt = digit_cnt + 9'd1;
                if (digit_cnt[0]) begin
                    hi_digit = hv[3:0];
                end else begin
                    last = ({1'b0, emit_cnt} + 9'd1) >= {1'b0, frame_len};
                    got = 1'b1;
                    r = make_result(cur_cmd, 1'b1, {hi_digit, hv[3:0]}, emit_cnt, last);
                    if (last) clear_frame();
                    else emit_cnt = emit_cnt + 8'd1;
                end
            end
        end
    endtask

    // offer one request, wait for it to be taken, then predict its result
    task automatic send_byte(input logic [7:0] ch, output logic got, output t_frame_result r);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(7) == 0) ? 120 : $urandom_range(1, 24);
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_rx_byte <= ch;
        do @(posedge i_clk); while (o_stall);
        frame_byte(ch, got, r);
        sent_cnt++;
    endtask

    task automatic send_random(input logic [7:0] ch);
        logic          got;
        t_frame_result r;
        send_byte(ch, got, r);
        if (got) frame_q.push_back(r);
    endtask

    // hex digit with an occasional stray character ahead of it
    task automatic send_digit(input logic [3:0] nib);
        logic [7:0] junk;
        if ($urandom_range(19) == 0) begin
            do junk = 8'($urandom_range(255)); while (hex_digit(junk) != 5'd0);
            send_random(junk);
        end else if ($urandom_range(59) == 0) begin
            send_random(8'($urandom_range(255)));
        end
        send_random(hex_char(nib));
    endtask

    task automatic note_mismatch(input string what, input t_frame_result want,
                                 input t_frame_result seen);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("%0t %s: expected cmd=%h known=%b data=%b byte=%h idx=%0d last=%b,",
                     $realtime, what, want.cmd, want.known, want.has_data, want.data,
                     want.index, want.last,
                     " got cmd=%h known=%b data=%b byte=%h idx=%0d last=%b",
                     seen.cmd, seen.known, seen.has_data, seen.data,
                     seen.index, seen.last);
    endtask

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_frame_result seen;
        t_frame_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            seen = '{o_command_code, o_known_command, o_has_data, o_data_byte,
                     o_data_index, o_last_of_command};
            if (frame_q.size() == 0) begin
                note_mismatch("unexpected result", NO_RES, seen);
            end else begin
                want = frame_q.pop_front();
                if (seen !== want) note_mismatch("result mismatch", want, seen);
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    t_rx_mode rx_mode = RX_FREE;
    int  mode_left = 0;
    int  hold_left = 0;
    logic hold_used = 1'b0;

    always @(posedge i_clk) begin
        if (hold_req && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(2));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (rx_mode)
                RX_FREE:  i_stall <= 1'b0;
                RX_COIN:  i_stall <= 1'($urandom_range(1));
                default:  i_stall <= (cyc % 4) != 0;
            endcase
        end
    end

    initial begin
        logic          got;
        t_frame_result r;
        logic [7:0]    letter;
        int            len;
        int            roll;
        logic          long_done;
        logic          paused;
        long_done = 1'b0;
        paused = 1'b0;
        clear_frame();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_byte(DIR_TABLE[i].ch, got, r);
            if (DIR_TABLE[i].typed) frame_q.push_back(DIR_TABLE[i].res);
            else if (got) frame_q.push_back(r);
        end

        sent_cnt = 0;
        while (sent_cnt < RANDOM_ITEMS || !long_done) begin
            if (sent_cnt >= HOLD_AT) hold_req <= 1'b1;
            if (!paused && sent_cnt >= PAUSE_AT) begin
                // drain the block before going on
                paused = 1'b1;
                i_valid <= 1'b0;
                do @(posedge i_clk); while (frame_q.size() != 0);
            end
            roll = $urandom_range(99);
            if (roll < 8) begin
                repeat ($urandom_range(1, 3)) send_random(8'($urandom_range(255)));
            end else if (roll < 22) begin
                send_random(hcf_pkg::LIST_CMD);
            end else begin
                letter = ($urandom_range(2) != 0) ? KNOWN_CMDS[$urandom_range(8)]
                                                  : 8'($urandom_range(33, 122));
                if (!long_done && sent_cnt >= LONG_AT) begin
                    len = 255;
                    long_done = 1'b1;
                end else if ($urandom_range(29) == 0) begin
                    len = $urandom_range(7, 40);
                end else begin
                    len = $urandom_range(0, 6);
                end
                send_random(letter);
                send_digit(4'(len >> 4));
                send_digit(4'(len));
                for (int k = 0; k < len; k++) begin
                    roll = $urandom_range(255);
                    send_digit(4'(roll >> 4));
                    send_digit(4'(roll));
                end
            end
        end

        i_valid <= 1'b0;
        while (frame_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && frame_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/hcf_pkg.sv
hw/rtl/hcf_front.sv
hw/rtl/hcf_queue.sv
hw/rtl/hcf_back.sv
hw/rtl/hex_command_framer_unit.sv
hw/rtl/hcf_checker.sv
tb/tb_top.sv
